// File: rtl/byps_pkg.sv
// ----------------------------------------------------------------------------
// byps_pkg: shared definitions of the bilinear YUV plane scaler
// Field widths, configuration register indexes, request, plane and chroma codes.
// ----------------------------------------------------------------------------
package byps_pkg;

	localparam int PlaneDepthDef = 65536;
	localparam int FracBitsDef   = 16;

	localparam int DimW    = 13;  // src_width, src_height
	localparam int FactW   = 8;   // up_factor, down_factor
	localparam int CoordW  = 12;  // out_x, out_y
	localparam int AddrInW = 16;  // write_addr
	localparam int PixW    = 8;
	localparam int DestW   = 24;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 13;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SRC_WIDTH   = 3'd0,
		CFG_SRC_HEIGHT  = 3'd1,
		CFG_UP_FACTOR   = 3'd2,
		CFG_DOWN_FACTOR = 3'd3,
		CFG_CHROMA_MODE = 3'd4
	} cfg_idx_t;

	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	localparam logic [1:0] PLANE_Y   = 2'd0;
	localparam logic [1:0] PLANE_BAD = 2'd3;

	localparam logic [1:0] CHROMA_444 = 2'd0;
	localparam logic [1:0] CHROMA_420 = 2'd2;

endpackage

// File: rtl/bilinear_yuv_plane_scaler_top.sv
// ----------------------------------------------------------------------------
// bilinear_yuv_plane_scaler_top: bilinear scaler over three stored YUV planes
// Sample store, shared restoring divider, four-read bilinear blend.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one beat is one request. A write beat
//    (req_type 0) stores write_value at write_addr of the named plane in the
//    cycle it is accepted and gives no result. A compute beat (req_type 1)
//    gives exactly one result beat on the output channel.
//  - Output channel (out_valid / out_stall): pixel, dest_index, out_of_range.
//    The result sits in an output register; the block takes the next request
//    while it waits, and only a finished compute stalls behind a full output.
//  - A compute beat runs through one shared divider, one quotient bit per
//    cycle over 20+FRAC_BITS bits, for the scaled width and height, then (in
//    range) for the source x and y. Then an address step (S_ADDR), four reads
//    on the single memory port (one a cycle), and the blend arithmetic
//    (S_RD4, S_MUL, S_ADD, S_MV1, S_MV2, S_FIN). An out-of-range request
//    skips the source divisions, the reads and the blend.
//  - PLANE_DEPTH must be a power of two; read indexes wrap modulo it.
//  - Reset clears control and reloads the register defaults (256x256, 1/1,
//    4:4:4). Sample store contents stay undefined until written.
//  - The user must write configuration (cfg_we / cfg_index / cfg_data) only while idle; unchecked.
// ----------------------------------------------------------------------------
module bilinear_yuv_plane_scaler_top #(
	parameter int PLANE_DEPTH = byps_pkg::PlaneDepthDef,
	parameter int FRAC_BITS   = byps_pkg::FracBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [byps_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [byps_pkg::CfgW-1:0]     cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [1:0]                    plane,
	input  logic [byps_pkg::AddrInW-1:0]  write_addr,
	input  logic [byps_pkg::PixW-1:0]     write_value,
	input  logic [byps_pkg::CoordW-1:0]   out_x,
	input  logic [byps_pkg::CoordW-1:0]   out_y,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [byps_pkg::PixW-1:0]     pixel,
	output logic [byps_pkg::DestW-1:0]    dest_index,
	output logic                          out_of_range
);

	localparam int AW   = $clog2(PLANE_DEPTH);
	localparam int MAW  = AW + 2;                 // {plane, index}
	localparam int DIM  = byps_pkg::DimW;
	localparam int NWW  = DIM + byps_pkg::FactW;  // scaled size width
	localparam int PRW  = byps_pkg::CoordW + byps_pkg::FactW;
	localparam int DVW  = PRW + FRAC_BITS;        // divider dividend width
	localparam int IPW  = DVW - FRAC_BITS;        // integer part width
	localparam int CW   = $clog2(DVW + 1);
	localparam int DNW  = byps_pkg::FactW + 1;    // divisor width
	localparam int FW1  = FRAC_BITS + 1;
	localparam int HW   = FRAC_BITS + 9;          // horizontal blend width
	localparam int SW   = HW + FW1;               // full sum width
	localparam logic [FW1-1:0] One = FW1'(1) << FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_CHECK, S_ADDR, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
		S_MUL, S_ADD, S_MV1, S_MV2, S_FIN, S_OUT
	} state_t;

	typedef enum logic [1:0] { D_NW, D_NH, D_SX, D_SY } div_sel_t;

	state_t   state_q;
	div_sel_t div_sel_q;

	// configuration registers
	logic [DIM-1:0] width_q, height_q;
	logic [7:0]     up_q, down_q;
	logic [1:0]     cmode_q;

	// request registers
	logic [1:0]                  plane_q;
	logic [byps_pkg::CoordW-1:0] ox_q, oy_q;

	// divider
	logic [DVW-1:0] div_num_q;
	logic [DNW-1:0] div_den_q;
	logic [DNW-1:0] div_rem_q;
	logic [CW-1:0]  div_cnt_q;
	logic [DNW:0]   trial;
	logic           ge;
	logic [DNW-1:0] rem_nxt;
	logic [DVW-1:0] num_nxt;

	logic [NWW-1:0] nw_q, nh_q;
	logic [DVW-1:0] sx_q, sy_q;

	// geometry
	logic [7:0]     up_eff, down_eff;
	logic           wsh, hsh;
	logic [DIM-1:0] pw, ph, pw_raw, ph_raw;
	logic [IPW-1:0] x1_raw, y1_raw;
	logic [DIM-1:0] x1, y1, x2, y2;
	logic           oor;

	logic [DIM-1:0]       x1_s2, x2_s2;
	logic [2*DIM-1:0]     row1_s2, row2_s2;
	logic [FRAC_BITS-1:0] dx_q, dy_q;
	logic [byps_pkg::DestW-1:0] dest_q;

	// memory
	logic [7:0]     mem_q [0:3*PLANE_DEPTH-1];
	logic [7:0]     rd_data_q;
	logic           mem_we;
	logic [MAW-1:0] mem_waddr, mem_raddr;
	logic [2*DIM:0] rd_sum;
	logic           rd_en;

	logic [7:0]  q11_q, q12_q, q21_q;
	logic [HW-1:0] pa_q, pb_q, pc_q, pd_q, top_q, bot_q;
	logic [SW-1:0] m1_q, m2_q;
	logic [SW-1:0] sum_full;
	logic [SW-2*FRAC_BITS-1:0] pix_wide;

	logic [7:0] pix_q;
	logic       oor_res_q;

	logic accept, out_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM'(256);
			height_q <= DIM'(256);
			up_q     <= 8'd1;
			down_q   <= 8'd1;
			cmode_q  <= byps_pkg::CHROMA_444;
		end else if (cfg_we) begin
			case (byps_pkg::cfg_idx_t'(cfg_index))
				byps_pkg::CFG_SRC_WIDTH:   width_q  <= cfg_data;
				byps_pkg::CFG_SRC_HEIGHT:  height_q <= cfg_data;
				byps_pkg::CFG_UP_FACTOR:   up_q     <= cfg_data[7:0];
				byps_pkg::CFG_DOWN_FACTOR: down_q   <= cfg_data[7:0];
				byps_pkg::CFG_CHROMA_MODE: cmode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// ---------------- geometry ----------------
	always_comb begin
		up_eff   = (up_q == 8'd0) ? 8'd1 : up_q;
		down_eff = (down_q == 8'd0) ? 8'd1 : down_q;
		wsh      = (plane_q != byps_pkg::PLANE_Y) && (cmode_q != byps_pkg::CHROMA_444);
		hsh      = (plane_q != byps_pkg::PLANE_Y) && (cmode_q >= byps_pkg::CHROMA_420);
		pw_raw   = width_q >> wsh;
		ph_raw   = height_q >> hsh;
		pw       = (pw_raw == '0) ? DIM'(1) : pw_raw;
		ph       = (ph_raw == '0) ? DIM'(1) : ph_raw;
		x1_raw   = sx_q[DVW-1:FRAC_BITS];
		y1_raw   = sy_q[DVW-1:FRAC_BITS];
		x1 = (x1_raw > IPW'(pw - DIM'(1))) ? pw - DIM'(1) : DIM'(x1_raw);
		y1 = (y1_raw > IPW'(ph - DIM'(1))) ? ph - DIM'(1) : DIM'(y1_raw);
		x2 = ({1'b0, x1} + 14'd1 < {1'b0, pw}) ? x1 + DIM'(1) : x1;
		y2 = ({1'b0, y1} + 14'd1 < {1'b0, ph}) ? y1 + DIM'(1) : y1;
		oor = (plane_q == byps_pkg::PLANE_BAD) || (NWW'(ox_q) >= nw_q)
			|| (NWW'(oy_q) >= nh_q);
	end

	// ---------------- divider step ----------------
	always_comb begin
		trial   = {div_rem_q, div_num_q[DVW-1]};
		ge      = trial >= {1'b0, div_den_q};
		rem_nxt = ge ? DNW'(trial - {1'b0, div_den_q}) : trial[DNW-1:0];
		num_nxt = {div_num_q[DVW-2:0], ge};
	end

	// ---------------- memory ----------------
	always_comb begin
		mem_we    = accept && (req_type == byps_pkg::REQ_WRITE)
			&& (plane != byps_pkg::PLANE_BAD) && (32'(write_addr) < 32'(PLANE_DEPTH));
		mem_waddr = {plane, AW'(write_addr)};
		rd_en     = 1'b1;
		case (state_q)
			S_RD0:   rd_sum = {1'b0, row1_s2} + (2*DIM+1)'(x1_s2);
			S_RD1:   rd_sum = {1'b0, row2_s2} + (2*DIM+1)'(x1_s2);
			S_RD2:   rd_sum = {1'b0, row1_s2} + (2*DIM+1)'(x2_s2);
			S_RD3:   rd_sum = {1'b0, row2_s2} + (2*DIM+1)'(x2_s2);
			default: begin
				rd_sum = '0;
				rd_en  = 1'b0;
			end
		endcase
		mem_raddr = {plane_q, AW'(rd_sum)};
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= write_value;
		if (rd_en)
			rd_data_q <= mem_q[mem_raddr];
	end

	// ---------------- blend ----------------
	assign sum_full = m1_q + m2_q;
	assign pix_wide = sum_full[SW-1:2*FRAC_BITS];

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_sel_q <= D_NW;
			div_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			// S_OUT reloads the output register itself
			if (out_valid && !out_stall && state_q != S_OUT)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && req_type == byps_pkg::REQ_COMPUTE) begin
						plane_q   <= plane;
						ox_q      <= out_x;
						oy_q      <= out_y;
						div_sel_q <= D_NW;
						div_num_q <= DVW'(width_q) * DVW'(up_eff);
						div_den_q <= {1'b0, down_eff};
						div_rem_q <= '0;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_cnt_q == CW'(DVW - 1)) begin
						div_cnt_q <= '0;
						div_rem_q <= '0;
						case (div_sel_q)
							D_NW: begin
								nw_q      <= NWW'(num_nxt);
								div_sel_q <= D_NH;
								div_num_q <= DVW'(height_q) * DVW'(up_eff);
							end
							D_NH: begin
								nh_q    <= NWW'(num_nxt);
								state_q <= S_CHECK;
							end
							D_SX: begin
								sx_q      <= num_nxt;
								div_sel_q <= D_SY;
								div_num_q <= DVW'({PRW'(oy_q) * PRW'(down_eff),
									{FRAC_BITS{1'b0}}});
								div_den_q <= hsh ? {up_eff, 1'b0} : {1'b0, up_eff};
							end
							default: begin
								sy_q    <= num_nxt;
								state_q <= S_ADDR;
							end
						endcase
					end else begin
						div_num_q <= num_nxt;
						div_rem_q <= rem_nxt;
						div_cnt_q <= div_cnt_q + CW'(1);
					end
				end
				S_CHECK: begin
					if (oor) begin
						pix_q     <= '0;
						dest_q    <= '0;
						oor_res_q <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						div_sel_q <= D_SX;
						div_num_q <= DVW'({PRW'(ox_q) * PRW'(down_eff), {FRAC_BITS{1'b0}}});
						div_den_q <= wsh ? {up_eff, 1'b0} : {1'b0, up_eff};
						div_rem_q <= '0;
						div_cnt_q <= '0;
						oor_res_q <= 1'b0;
						state_q   <= S_DIV;
					end
				end
				S_ADDR: begin
					x1_s2   <= x1;
					x2_s2   <= x2;
					row1_s2 <= y1 * pw;
					row2_s2 <= y2 * pw;
					dx_q    <= sx_q[FRAC_BITS-1:0];
					dy_q    <= sy_q[FRAC_BITS-1:0];
					dest_q  <= byps_pkg::DestW'(oy_q >> hsh) * byps_pkg::DestW'(nw_q >> wsh)
						+ byps_pkg::DestW'(ox_q >> wsh);
					state_q <= S_RD0;
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					q11_q   <= rd_data_q;
					state_q <= S_RD2;
				end
				S_RD2: begin
					q12_q   <= rd_data_q;
					state_q <= S_RD3;
				end
				S_RD3: begin
					q21_q   <= rd_data_q;
					state_q <= S_RD4;
				end
				S_RD4: begin
					// rd_data_q holds the bottom-right neighbour
					pa_q    <= HW'(q11_q) * HW'(One - FW1'(dx_q));
					pb_q    <= HW'(q21_q) * HW'(dx_q);
					pc_q    <= HW'(q12_q) * HW'(One - FW1'(dx_q));
					pd_q    <= HW'(rd_data_q) * HW'(dx_q);
					state_q <= S_MUL;
				end
				S_MUL: begin
					top_q   <= pa_q + pb_q;
					bot_q   <= pc_q + pd_q;
					state_q <= S_ADD;
				end
				S_ADD: begin
					m1_q    <= SW'(top_q) * SW'(One - FW1'(dy_q));
					state_q <= S_MV1;
				end
				S_MV1: begin
					m2_q    <= SW'(bot_q) * SW'(dy_q);
					state_q <= S_MV2;
				end
				S_MV2: state_q <= S_FIN;
				S_FIN: begin
					pix_q   <= (pix_wide > (SW-2*FRAC_BITS)'(255)) ? 8'd255 : pix_wide[7:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						pixel        <= pix_q;
						dest_index   <= dest_q;
						out_of_range <= oor_res_q;
						out_valid    <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bilinear_yuv_plane_scaler_top
// Drives store and compute requests under random idling on both channels and
// checks every result beat against an in-bench scaler model, over several
// register settings.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] PLANE_CB = 2'd1;
	localparam logic [1:0] PLANE_CR = 2'd2;
	localparam logic [1:0] CHROMA_422    = 2'd1;
	localparam logic [1:0] CHROMA_UNUSED = 2'd3;
	localparam int DEPTH      = 65536;
	localparam int FRAC       = 16;
	localparam int DRAIN      = 400;      // settling wait after the last expected result
	localparam int LIMIT      = 3000000;  // cycles
	localparam int HOLD_CYCLES = 3000;    // long receiver hold-off

	typedef struct {
		logic [7:0]  pix;
		logic [23:0] dest;
		logic        oor;
		int          n_reads;
		int          addr [4];
	} scaled_t;

	typedef struct {
		logic [7:0]  pix;
		logic [23:0] dest;
		logic        oor;
	} result_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [byps_pkg::CfgIdxW-1:0] cfg_index;
	logic [byps_pkg::CfgW-1:0]    cfg_data;
	logic in_valid, in_stall, req_type;
	logic [1:0] plane;
	logic [byps_pkg::AddrInW-1:0] write_addr;
	logic [byps_pkg::PixW-1:0] write_value;
	logic [byps_pkg::CoordW-1:0] out_x, out_y;
	logic out_valid, out_stall;
	logic [byps_pkg::PixW-1:0] pixel;
	logic [byps_pkg::DestW-1:0] dest_index;
	logic out_of_range;

	bilinear_yuv_plane_scaler_top dut (.*);

	// model copy of the registers and the sample store
	logic [12:0] m_width, m_height;
	logic [7:0]  m_up, m_down;
	logic [1:0]  m_chroma;
	logic [7:0]  sample_mem [3][DEPTH];
	bit          sample_set [3][DEPTH];

	result_t pending_results [$];
	int  errors = 0;
	int  cycles = 0;
	bit  calm = 0;        // no idling on either side while set (hold-off aside)
	bit  hold_out = 0;    // receiver long hold-off request

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("%0t timeout", $time);
			$display("bilinear_yuv_plane_scaler_top test failed");
			$finish;
		end
	end

	// bilinear mapping of one output coordinate onto the stored planes
	function automatic scaled_t scale_sample(logic [1:0] pl, longint unsigned ox,
			longint unsigned oy);
		scaled_t r;
		longint unsigned up, dn, nw, nh, wm, hm, pw, ph, one;
		longint unsigned sx, sy, x1, y1, x2, y2, dx, dy, sum, pix;
		longint unsigned q11, q12, q21, q22;
		r.pix = 0; r.dest = 0; r.oor = 1; r.n_reads = 0;
		up = (m_up == 0) ? 1 : m_up;
		dn = (m_down == 0) ? 1 : m_down;
		nw = longint'(m_width) * up / dn;
		nh = longint'(m_height) * up / dn;
		if (pl == byps_pkg::PLANE_BAD || ox >= nw || oy >= nh)
			return r;
		wm = 1; hm = 1;
		if (pl != byps_pkg::PLANE_Y) begin
			if (m_chroma == CHROMA_422)
				wm = 2;
			else if (m_chroma != byps_pkg::CHROMA_444) begin
				wm = 2; hm = 2;
			end
		end
		pw = m_width / wm;  if (pw == 0) pw = 1;
		ph = m_height / hm; if (ph == 0) ph = 1;
		one = 64'd1 << FRAC;
		sx = ((ox * dn) << FRAC) / (up * wm);
		sy = ((oy * dn) << FRAC) / (up * hm);
		x1 = sx >> FRAC; y1 = sy >> FRAC;
		dx = sx & (one - 1); dy = sy & (one - 1);
		if (x1 > pw - 1) x1 = pw - 1;
		if (y1 > ph - 1) y1 = ph - 1;
		x2 = (x1 + 1 < pw) ? x1 + 1 : x1;
		y2 = (y1 + 1 < ph) ? y1 + 1 : y1;
		r.addr[0] = int'((y1 * pw + x1) % DEPTH);
		r.addr[1] = int'((y2 * pw + x1) % DEPTH);
		r.addr[2] = int'((y1 * pw + x2) % DEPTH);
		r.addr[3] = int'((y2 * pw + x2) % DEPTH);
		r.n_reads = 4;
		q11 = sample_mem[pl][r.addr[0]];
		q12 = sample_mem[pl][r.addr[1]];
		q21 = sample_mem[pl][r.addr[2]];
		q22 = sample_mem[pl][r.addr[3]];
		sum = q11 * (one - dx) * (one - dy) + q21 * dx * (one - dy)
			+ q12 * (one - dx) * dy + q22 * dx * dy;
		pix = sum >> (2 * FRAC);
		if (pix > 255) pix = 255;
		r.pix = pix[7:0];
		r.dest = 24'((oy / hm) * (nw / wm) + ox / wm);
		r.oor = 0;
		return r;
	endfunction

	// sender gap: mostly none or short, now and then long
	task automatic request_gap();
		int r, n;
		if (calm) return;
		r = $urandom_range(0, 99);
		n = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(4, 40);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// one request beat; the model is updated at acceptance
	task automatic send_request(logic rq, logic [1:0] pl, logic [15:0] addr,
			logic [7:0] val, logic [11:0] ox, logic [11:0] oy);
		scaled_t s;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rq; plane <= pl; write_addr <= addr;
		write_value <= val; out_x <= ox; out_y <= oy;
		do @(posedge clk); while (in_stall);
		if (rq == byps_pkg::REQ_WRITE) begin
			if (pl != byps_pkg::PLANE_BAD) begin
				sample_mem[pl][addr] = val;
				sample_set[pl][addr] = 1;
			end
		end else begin
			s = scale_sample(pl, ox, oy);
			pending_results.push_back('{s.pix, s.dest, s.oor});
		end
	endtask

	task automatic store_sample(logic [1:0] pl, logic [15:0] addr, logic [7:0] val);
		send_request(byps_pkg::REQ_WRITE, pl, addr, val, 12'($urandom), 12'($urandom));
		request_gap();
	endtask

	// compute beat; neighbors never written yet get a sample first
	task automatic compute_sample(logic [1:0] pl, logic [11:0] ox, logic [11:0] oy);
		scaled_t s;
		s = scale_sample(pl, ox, oy);
		for (int i = 0; i < s.n_reads; i++)
			if (!sample_set[pl][s.addr[i]])
				store_sample(pl, 16'(s.addr[i]), 8'($urandom));
		send_request(byps_pkg::REQ_COMPUTE, pl, 16'($urandom), 8'($urandom), ox, oy);
		request_gap();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// all five registers, back to back, only while the block is idle
	task automatic set_registers(int w, int h, int up, int dn, int cm);
		int vals [5];
		wait_idle();
		vals = '{w, h, up, dn, cm};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= byps_pkg::CfgIdxW'(i);
			cfg_data <= byps_pkg::CfgW'(vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		m_width = 13'(w); m_height = 13'(h); m_up = 8'(up); m_down = 8'(dn);
		m_chroma = 2'(cm);
	endtask

	function automatic int scaled_span(int dim);
		longint unsigned up, dn, n;
		up = (m_up == 0) ? 1 : m_up;
		dn = (m_down == 0) ? 1 : m_down;
		n = longint'(dim) * up / dn;
		return (n == 0) ? 0 : ((n > 4096) ? 4095 : int'(n - 1));
	endfunction

	// directed: reset defaults, field extremes, bad plane, out of range
	task automatic test_directed();
		store_sample(byps_pkg::PLANE_Y, 16'd0, 8'd255);
		store_sample(byps_pkg::PLANE_Y, 16'd1, 8'd0);
		store_sample(byps_pkg::PLANE_Y, 16'd256, 8'd128);
		store_sample(byps_pkg::PLANE_Y, 16'd257, 8'd77);
		store_sample(PLANE_CR, 16'hFFFF, 8'hFF);
		store_sample(byps_pkg::PLANE_BAD, 16'd5, 8'hAA);          // ignored
		compute_sample(byps_pkg::PLANE_Y, 12'd0, 12'd0);
		compute_sample(byps_pkg::PLANE_Y, 12'd255, 12'd255);      // bottom right corner
		compute_sample(byps_pkg::PLANE_Y, 12'd256, 12'd0);        // just out of range
		compute_sample(byps_pkg::PLANE_Y, 12'd0, 12'd4095);
		compute_sample(byps_pkg::PLANE_Y, 12'hFFF, 12'hFFF);
		compute_sample(byps_pkg::PLANE_BAD, 12'd3, 12'd3);        // bad plane result
		compute_sample(PLANE_CB, 12'd17, 12'd200);
		compute_sample(PLANE_CR, 12'd255, 12'd1);
		// fractional positions and chroma halving
		set_registers(5, 3, 7, 3, byps_pkg::CHROMA_420);
		compute_sample(byps_pkg::PLANE_Y, 12'd4, 12'd6);
		compute_sample(PLANE_CB, 12'd11, 12'd6);        // out of range: ox equals the scaled width
		compute_sample(PLANE_CR, 12'd1, 12'd2);
	endtask

	// random traffic under one register setting
	task automatic random_phase(int w, int h, int up, int dn, int cm, int n_ops);
		int r, xm, ym;
		logic [1:0] pl;
		set_registers(w, h, up, dn, cm);
		calm = ($urandom_range(0, 4) == 0);
		xm = scaled_span(w);
		ym = scaled_span(h);
		repeat (n_ops) begin
			r = $urandom_range(0, 99);
			pl = 2'($urandom_range(0, 2));
			if (r < 70 && (w * up != 0))
				compute_sample(pl, 12'($urandom_range(0, xm)), 12'($urandom_range(0, ym)));
			else if (r < 85)
				store_sample(2'($urandom), 16'($urandom), 8'($urandom));
			else
				compute_sample(2'($urandom), 12'($urandom), 12'($urandom));
		end
		calm = 0;
	endtask

	task automatic test_settings();
		random_phase(256, 256, 1, 1, byps_pkg::CHROMA_444, 60);
		random_phase(1, 1, 1, 1, byps_pkg::CHROMA_444, 25);
		random_phase(4096, 4096, 255, 1, byps_pkg::CHROMA_420, 40);
		random_phase(8191, 3, 1, 255, CHROMA_422, 40);
		random_phase(0, 5, 3, 2, CHROMA_UNUSED, 15);      // nothing in range
		random_phase(16, 12, 3, 0, CHROMA_422, 70);      // zero down factor
		random_phase(7, 9, 0, 4, byps_pkg::CHROMA_420, 70);        // zero up factor
		random_phase(13, 11, 5, 3, CHROMA_UNUSED, 90);
		random_phase(40, 30, 2, 5, CHROMA_422, 90);
		random_phase(4096, 1, 1, 1, byps_pkg::CHROMA_444, 40);
		random_phase(1, 8191, 200, 199, byps_pkg::CHROMA_420, 40);
		random_phase(9, 6, 17, 5, byps_pkg::CHROMA_444, 90);
	endtask

	// receiver stops for a long stretch while requests keep coming
	task automatic test_backpressure();
		set_registers(10, 8, 3, 2, byps_pkg::CHROMA_420);
		hold_out = 1;
		calm = 1;
		repeat (12)
			compute_sample(2'($urandom_range(0, 2)), 12'($urandom_range(0, 14)),
				12'($urandom_range(0, 11)));
		calm = 0;
	endtask

	// receiver: random stalls, plus the long hold-off on request
	initial begin
		int r;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 0;
			end else if (calm)
				out_stall <= 1'b0;
			else begin
				r = $urandom_range(0, 99);
				if (r < 65)
					out_stall <= 1'b0;
				else if (r < 95)
					out_stall <= 1'b1;
				else begin
					out_stall <= 1'b1;
					repeat ($urandom_range(5, 50)) @(negedge clk);
				end
			end
		end
	end

	// result checker: oldest expectation against each accepted beat
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result beat: pixel %0d dest %0d oor %0b",
					$time, pixel, dest_index, out_of_range);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (pixel !== e.pix) begin
					$display("%0t pixel: expected %0d actual %0d", $time, e.pix, pixel);
					errors++;
				end
				if (dest_index !== e.dest) begin
					$display("%0t dest_index: expected %0d actual %0d",
						$time, e.dest, dest_index);
					errors++;
				end
				if (out_of_range !== e.oor) begin
					$display("%0t out_of_range: expected %0b actual %0b",
						$time, e.oor, out_of_range);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; req_type = byps_pkg::REQ_WRITE; plane = byps_pkg::PLANE_Y;
		write_addr = '0; write_value = '0; out_x = '0; out_y = '0;
		m_width = 13'd256; m_height = 13'd256; m_up = 8'd1; m_down = 8'd1;
		m_chroma = byps_pkg::CHROMA_444;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_settings();
		wait_idle();
		if (errors == 0)
			$display("bilinear_yuv_plane_scaler_top test passed");
		else
			$display("bilinear_yuv_plane_scaler_top test failed");
		$finish;
	end

endmodule

// File: bilinear_yuv_plane_scaler_top.f
rtl/byps_pkg.sv
rtl/bilinear_yuv_plane_scaler_top.sv
sim/testbench.sv
